### design/ilff_pkg.sv
// ----------------------------------------------------------------------------
// ilff_pkg
// Shared types and constants of the first-fit boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ilff_pkg;

	// byte offsets are signed so that a walk below zero reads as outside the heap
	localparam int ADDR_W = 40;
	localparam int WORD_W = 32;
	localparam int REQ_W  = 18;
	localparam int CFG_W  = 17;
	localparam int NEED_W = 19;
	localparam int GSZ_W  = 20;

	typedef logic signed [ADDR_W-1:0] addr_t;

	localparam addr_t WSIZE = addr_t'(4);
	localparam addr_t DSIZE = addr_t'(8);

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	// post-init heap image
	localparam int            INIT_PRO_A  = 1;
	localparam int            INIT_PRO_B  = 2;
	localparam int            INIT_HDR    = 3;
	localparam int            INIT_FTR    = 1026;
	localparam int            INIT_EPI    = 1027;
	localparam logic [31:0]   INIT_PRO_V  = 32'd9;
	localparam logic [31:0]   INIT_FREE_V = 32'd4096;
	localparam logic [31:0]   INIT_EPI_V  = 32'd1;
	localparam logic [31:0]   INIT_BRK    = 32'd4112;
	localparam logic [CFG_W-1:0] CHUNK_RST = 17'd4096;

	// datapath commands
	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_CLR,
		CMD_LOAD,
		CMD_F_RH,
		CMD_F_WH,
		CMD_F_WF,
		CMD_M_R8,
		CMD_M_RB,
		CMD_M_RBF,
		CMD_M_RP,
		CMD_M_RN,
		CMD_M_CASE,
		CMD_M_PU_WH,
		CMD_M_PU_WF,
		CMD_M_NU_WF,
		CMD_M_NU_WH,
		CMD_M_NN_R,
		CMD_M_NN_WH,
		CMD_M_NN_WF,
		CMD_A_RH,
		CMD_A_STEP,
		CMD_G_OOM,
		CMD_G_HDR,
		CMD_G_WF,
		CMD_G_WE,
		CMD_P_RH,
		CMD_P_CHK,
		CMD_P_WF,
		CMD_P_WH2,
		CMD_P_WF2,
		CMD_EMIT
	} cmd_t;

	// datapath status towards the controller
	typedef struct packed {
		logic clr_last;
		logic in_free;
		logic in_zero;
		logic chk_zero;
		logic chk_fit;
		logic pu;
		logic nu;
		logic oom;
		logic split;
		logic mode_free;
		logic out_full;
	} dp_status_t;

endpackage

### design/ilff_ctrl.sv
// ----------------------------------------------------------------------------
// ilff_ctrl
// Sequencer of the allocator: clearing pass, free, merge, first-fit walk,
// heap growth and block placement.
// ----------------------------------------------------------------------------
module ilff_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ilff_pkg::dp_status_t st,
	output ilff_pkg::cmd_t      cmd
);

	typedef enum logic [28:0] {
		S_CLR      = 29'b1 << 0,
		S_IDLE     = 29'b1 << 1,
		S_F_RH     = 29'b1 << 2,
		S_F_WH     = 29'b1 << 3,
		S_F_WF     = 29'b1 << 4,
		S_M_R8     = 29'b1 << 5,
		S_M_RB     = 29'b1 << 6,
		S_M_RBF    = 29'b1 << 7,
		S_M_RP     = 29'b1 << 8,
		S_M_RN     = 29'b1 << 9,
		S_M_CASE   = 29'b1 << 10,
		S_M_PU_WH  = 29'b1 << 11,
		S_M_PU_WF  = 29'b1 << 12,
		S_M_NU_WF  = 29'b1 << 13,
		S_M_NU_WH  = 29'b1 << 14,
		S_M_NN_R   = 29'b1 << 15,
		S_M_NN_WH  = 29'b1 << 16,
		S_M_NN_WF  = 29'b1 << 17,
		S_A_RH     = 29'b1 << 18,
		S_A_CHK    = 29'b1 << 19,
		S_G_CHK    = 29'b1 << 20,
		S_G_WF     = 29'b1 << 21,
		S_G_WE     = 29'b1 << 22,
		S_P_RH     = 29'b1 << 23,
		S_P_CHK    = 29'b1 << 24,
		S_P_WF     = 29'b1 << 25,
		S_P_WH2    = 29'b1 << 26,
		S_P_WF2    = 29'b1 << 27,
		S_DONE     = 29'b1 << 28
	} state_t;

	state_t state_q, state_d;
	state_t merge_end;

	assign in_stall  = (state_q != S_IDLE);
	assign merge_end = st.mode_free ? S_DONE : S_P_RH;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd     = ilff_pkg::CMD_NOP;
		case (state_q)
			S_CLR: begin
				cmd = ilff_pkg::CMD_CLR;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd = ilff_pkg::CMD_LOAD;
					if (st.in_free)      state_d = S_F_RH;
					else if (st.in_zero) state_d = S_DONE;
					else                 state_d = S_A_RH;
				end
			end
			S_F_RH: begin
				cmd = ilff_pkg::CMD_F_RH;
				state_d = S_F_WH;
			end
			S_F_WH: begin
				cmd = ilff_pkg::CMD_F_WH;
				state_d = S_F_WF;
			end
			S_F_WF: begin
				cmd = ilff_pkg::CMD_F_WF;
				state_d = S_M_R8;
			end
			S_M_R8: begin
				cmd = ilff_pkg::CMD_M_R8;
				state_d = S_M_RB;
			end
			S_M_RB: begin
				cmd = ilff_pkg::CMD_M_RB;
				state_d = S_M_RBF;
			end
			S_M_RBF: begin
				cmd = ilff_pkg::CMD_M_RBF;
				state_d = S_M_RP;
			end
			S_M_RP: begin
				cmd = ilff_pkg::CMD_M_RP;
				state_d = S_M_RN;
			end
			S_M_RN: begin
				cmd = ilff_pkg::CMD_M_RN;
				state_d = S_M_CASE;
			end
			S_M_CASE: begin
				cmd = ilff_pkg::CMD_M_CASE;
				if (st.pu && st.nu) state_d = merge_end;
				else if (st.pu)     state_d = S_M_PU_WH;
				else if (st.nu)     state_d = S_M_NU_WF;
				else                state_d = S_M_NN_R;
			end
			S_M_PU_WH: begin
				cmd = ilff_pkg::CMD_M_PU_WH;
				state_d = S_M_PU_WF;
			end
			S_M_PU_WF: begin
				cmd = ilff_pkg::CMD_M_PU_WF;
				state_d = merge_end;
			end
			S_M_NU_WF: begin
				cmd = ilff_pkg::CMD_M_NU_WF;
				state_d = S_M_NU_WH;
			end
			S_M_NU_WH: begin
				cmd = ilff_pkg::CMD_M_NU_WH;
				state_d = merge_end;
			end
			S_M_NN_R: begin
				cmd = ilff_pkg::CMD_M_NN_R;
				state_d = S_M_NN_WH;
			end
			S_M_NN_WH: begin
				cmd = ilff_pkg::CMD_M_NN_WH;
				state_d = S_M_NN_WF;
			end
			S_M_NN_WF: begin
				cmd = ilff_pkg::CMD_M_NN_WF;
				state_d = merge_end;
			end
			S_A_RH: begin
				cmd = ilff_pkg::CMD_A_RH;
				state_d = S_A_CHK;
			end
			S_A_CHK: begin
				if (st.chk_zero)     state_d = S_G_CHK;
				else if (st.chk_fit) state_d = S_P_RH;
				else begin
					cmd = ilff_pkg::CMD_A_STEP;
					state_d = S_A_RH;
				end
			end
			S_G_CHK: begin
				if (st.oom) begin
					cmd = ilff_pkg::CMD_G_OOM;
					state_d = S_DONE;
				end else begin
					cmd = ilff_pkg::CMD_G_HDR;
					state_d = S_G_WF;
				end
			end
			S_G_WF: begin
				cmd = ilff_pkg::CMD_G_WF;
				state_d = S_G_WE;
			end
			S_G_WE: begin
				cmd = ilff_pkg::CMD_G_WE;
				state_d = S_M_R8;
			end
			S_P_RH: begin
				cmd = ilff_pkg::CMD_P_RH;
				state_d = S_P_CHK;
			end
			S_P_CHK: begin
				cmd = ilff_pkg::CMD_P_CHK;
				state_d = S_P_WF;
			end
			S_P_WF: begin
				cmd = ilff_pkg::CMD_P_WF;
				state_d = st.split ? S_P_WH2 : S_DONE;
			end
			S_P_WH2: begin
				cmd = ilff_pkg::CMD_P_WH2;
				state_d = S_P_WF2;
			end
			S_P_WF2: begin
				cmd = ilff_pkg::CMD_P_WF2;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!st.out_full) begin
					cmd = ilff_pkg::CMD_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_d;
	end

endmodule

### design/ilff_dpath.sv
// ----------------------------------------------------------------------------
// ilff_dpath
// Heap word store, address and size arithmetic, break and chunk registers,
// and the result register of the allocator.
// ----------------------------------------------------------------------------
module ilff_dpath #(
	parameter int HEAP_WORDS = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ilff_pkg::cmd_t                cmd,
	output ilff_pkg::dp_status_t          st,
	input  logic                          mode,
	input  logic [ilff_pkg::REQ_W-1:0]    request_bytes,
	input  logic [ilff_pkg::REQ_W-1:0]    free_addr,
	input  logic                          cfg_wr_en,
	input  logic [ilff_pkg::CFG_W-1:0]    cfg_wr_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ilff_pkg::REQ_W-1:0]    payload_addr,
	output logic [1:0]                    status
);

	localparam int IW = $clog2(HEAP_WORDS);
	localparam ilff_pkg::addr_t HEAP_BYTES = ilff_pkg::addr_t'(4 * HEAP_WORDS);

	// size field of a tag word
	function automatic ilff_pkg::addr_t size_of(input logic [31:0] w);
		size_of = ilff_pkg::addr_t'({w[31:3], 3'b000});
	endfunction

	function automatic ilff_pkg::addr_t ext32(input logic [31:0] v);
		ext32 = ilff_pkg::addr_t'({1'b0, v});
	endfunction

	function automatic logic in_heap(input ilff_pkg::addr_t a);
		in_heap = (a >= ilff_pkg::addr_t'(0)) && (a < HEAP_BYTES);
	endfunction

	// heap store
	logic [31:0] heap_q [HEAP_WORDS];
	logic [31:0] rd_q;
	logic        rd_ok_q;
	logic [31:0] rw;

	ilff_pkg::addr_t mem_addr;
	logic            mem_we;
	logic [31:0]     mem_wd;
	logic [IW-1:0]   mem_idx;
	logic            mem_ok;

	// working registers
	logic [IW-1:0]               clr_idx_q;
	logic                        mode_q;
	ilff_pkg::addr_t             p_q, b_q, n_q, nf_q, t_q, sp_q, sb_q, brk_q;
	logic [31:0]                 sz_q, have_q;
	logic                        pu_q, split_q, hok_q, hok2_q;
	logic [ilff_pkg::NEED_W-1:0] need_q;
	logic [ilff_pkg::GSZ_W-1:0]  gsz_q;
	logic [ilff_pkg::CFG_W-1:0]  chunk_q;
	logic [ilff_pkg::REQ_W-1:0]  res_addr_q;
	logic [1:0]                  res_st_q;
	logic                        out_valid_q;
	logic [ilff_pkg::REQ_W-1:0]  out_addr_q;
	logic [1:0]                  out_st_q;

	// request size and growth size
	logic [ilff_pkg::NEED_W-1:0] r19, need_d, ext19;
	logic [16:0]                 gw;
	logic [17:0]                 gs;
	logic [ilff_pkg::GSZ_W-1:0]  gsz_d;

	// derived values
	ilff_pkg::addr_t rsz, gsz_a, split_fs, hn_fs;
	logic [31:0]     put_v, hn;
	logic [19:0]     need16;
	logic [31:0]     clr_wd;

	assign rw    = rd_ok_q ? rd_q : 32'd0;
	assign rsz   = size_of(rw);
	assign gsz_a = ilff_pkg::addr_t'(gsz_q);

	always_comb begin
		r19    = {1'b0, request_bytes} + 19'd15;
		need_d = (request_bytes <= 18'd8) ? 19'd16 : {r19[18:3], 3'b000};
		ext19  = (need_d > {2'b00, chunk_q}) ? need_d : {2'b00, chunk_q};
		gw     = ext19[18:2];
		gs     = {1'b0, gw} + 18'(gw[0]);
		gsz_d  = {gs, 2'b00};
	end

	always_comb begin
		need16   = {1'b0, need_q} + 20'd16;
		put_v    = split_q ? {13'd0, need_q} : have_q;
		split_fs = hok_q ? ext32(put_v) : ilff_pkg::addr_t'(0);
		hn       = have_q - {13'd0, need_q};
		hn_fs    = hok2_q ? ext32(hn) : ilff_pkg::addr_t'(0);
	end

	// post-init image word for the clearing pass
	always_comb begin
		clr_wd = 32'd0;
		if (clr_idx_q == IW'(ilff_pkg::INIT_PRO_A) || clr_idx_q == IW'(ilff_pkg::INIT_PRO_B))
			clr_wd = ilff_pkg::INIT_PRO_V;
		else if (clr_idx_q == IW'(ilff_pkg::INIT_HDR) || clr_idx_q == IW'(ilff_pkg::INIT_FTR))
			clr_wd = ilff_pkg::INIT_FREE_V;
		else if (clr_idx_q == IW'(ilff_pkg::INIT_EPI))
			clr_wd = ilff_pkg::INIT_EPI_V;
	end

	// store address and write data per command
	always_comb begin
		mem_addr = p_q - ilff_pkg::WSIZE;
		mem_we   = 1'b0;
		mem_wd   = sz_q;
		case (cmd)
			ilff_pkg::CMD_CLR: begin
				mem_addr = ilff_pkg::addr_t'({clr_idx_q, 2'b00});
				mem_we   = 1'b1;
				mem_wd   = clr_wd;
			end
			ilff_pkg::CMD_F_WH: begin
				mem_we = 1'b1;
				mem_wd = {rw[31:3], 3'b000};
			end
			ilff_pkg::CMD_F_WF: begin
				mem_addr = p_q + t_q - ilff_pkg::DSIZE;
				mem_we   = 1'b1;
				mem_wd   = t_q[31:0];
			end
			ilff_pkg::CMD_M_R8:  mem_addr = p_q - ilff_pkg::DSIZE;
			ilff_pkg::CMD_M_RB:  mem_addr = p_q - rsz - ilff_pkg::WSIZE;
			ilff_pkg::CMD_M_RBF: mem_addr = b_q + rsz - ilff_pkg::DSIZE;
			ilff_pkg::CMD_M_RN:  mem_addr = p_q + rsz - ilff_pkg::WSIZE;
			ilff_pkg::CMD_M_CASE: mem_addr = n_q + rsz - ilff_pkg::DSIZE;
			ilff_pkg::CMD_M_PU_WH: mem_we = 1'b1;
			ilff_pkg::CMD_M_PU_WF: begin
				mem_addr = p_q + (in_heap(p_q - ilff_pkg::WSIZE) ? size_of(sz_q)
					: ilff_pkg::addr_t'(0)) - ilff_pkg::DSIZE;
				mem_we   = 1'b1;
			end
			ilff_pkg::CMD_M_NU_WF: begin
				mem_addr = p_q + sp_q - ilff_pkg::DSIZE;
				mem_we   = 1'b1;
			end
			ilff_pkg::CMD_M_NU_WH, ilff_pkg::CMD_M_NN_WH: begin
				mem_addr = b_q - ilff_pkg::WSIZE;
				mem_we   = 1'b1;
			end
			ilff_pkg::CMD_M_NN_WF: begin
				mem_addr = nf_q;
				mem_we   = 1'b1;
			end
			ilff_pkg::CMD_G_HDR: begin
				mem_addr = brk_q - ilff_pkg::WSIZE;
				mem_we   = 1'b1;
				mem_wd   = 32'(gsz_q);
			end
			ilff_pkg::CMD_G_WF: begin
				mem_addr = p_q + gsz_a - ilff_pkg::DSIZE;
				mem_we   = 1'b1;
				mem_wd   = 32'(gsz_q);
			end
			ilff_pkg::CMD_G_WE: begin
				mem_addr = p_q + gsz_a - ilff_pkg::WSIZE;
				mem_we   = 1'b1;
				mem_wd   = ilff_pkg::INIT_EPI_V;
			end
			ilff_pkg::CMD_P_CHK: begin
				mem_we = 1'b1;
				mem_wd = ((rw[31:3] >= need16[19:3]) ? {13'd0, need_q}
					: {rw[31:3], 3'b000}) | 32'd1;
			end
			ilff_pkg::CMD_P_WF: begin
				mem_addr = p_q + split_fs - ilff_pkg::DSIZE;
				mem_we   = 1'b1;
				mem_wd   = put_v | 32'd1;
			end
			ilff_pkg::CMD_P_WH2: begin
				mem_addr = b_q - ilff_pkg::WSIZE;
				mem_we   = 1'b1;
				mem_wd   = hn;
			end
			ilff_pkg::CMD_P_WF2: begin
				mem_addr = b_q + hn_fs - ilff_pkg::DSIZE;
				mem_we   = 1'b1;
				mem_wd   = hn;
			end
			default: ;
		endcase
	end

	assign mem_idx = mem_addr[IW+1:2];
	assign mem_ok  = in_heap(mem_addr);

	// single port store with registered read
	always_ff @(posedge clk) begin
		if (mem_we && mem_ok) heap_q[mem_idx] <= mem_wd;
		rd_q <= heap_q[mem_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_ok_q <= 1'b0;
		else         rd_ok_q <= mem_ok;
	end

	// payload registers per command
	always_ff @(posedge clk) begin
		case (cmd)
			ilff_pkg::CMD_LOAD: begin
				mode_q     <= mode;
				p_q        <= mode ? ilff_pkg::addr_t'(free_addr) : ilff_pkg::DSIZE;
				need_q     <= need_d;
				gsz_q      <= gsz_d;
				res_addr_q <= '0;
				res_st_q   <= (!mode && request_bytes == '0) ? ilff_pkg::ST_ZERO
					: ilff_pkg::ST_OK;
			end
			ilff_pkg::CMD_F_WH: t_q <= rsz;
			ilff_pkg::CMD_M_RB: b_q <= p_q - rsz;
			ilff_pkg::CMD_M_RBF: sb_q <= rsz;
			ilff_pkg::CMD_M_RP: pu_q <= rw[0];
			ilff_pkg::CMD_M_RN: begin
				sp_q <= rsz;
				n_q  <= p_q + rsz;
			end
			ilff_pkg::CMD_M_CASE: begin
				sz_q <= pu_q ? (sp_q[31:0] + rsz[31:0]) : (sp_q[31:0] + sb_q[31:0]);
				nf_q <= n_q + rsz - ilff_pkg::DSIZE;
			end
			ilff_pkg::CMD_M_NN_R: sz_q <= sz_q + rsz[31:0];
			ilff_pkg::CMD_M_NU_WH, ilff_pkg::CMD_M_NN_WF: p_q <= b_q;
			ilff_pkg::CMD_A_STEP: p_q <= p_q + rsz;
			ilff_pkg::CMD_G_OOM: res_st_q <= ilff_pkg::ST_OOM;
			ilff_pkg::CMD_G_HDR: p_q <= brk_q;
			ilff_pkg::CMD_P_CHK: begin
				have_q     <= {rw[31:3], 3'b000};
				split_q    <= (rw[31:3] >= need16[19:3]);
				hok_q      <= in_heap(p_q - ilff_pkg::WSIZE);
				res_addr_q <= p_q[ilff_pkg::REQ_W-1:0];
			end
			ilff_pkg::CMD_P_WF: b_q <= p_q + split_fs;
			ilff_pkg::CMD_P_WH2: hok2_q <= in_heap(b_q - ilff_pkg::WSIZE);
			ilff_pkg::CMD_EMIT: begin
				out_addr_q <= res_addr_q;
				out_st_q   <= res_st_q;
			end
			default: ;
		endcase
	end

	// clearing index, break, chunk and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			brk_q       <= ilff_pkg::addr_t'(ilff_pkg::INIT_BRK);
			chunk_q     <= ilff_pkg::CHUNK_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == ilff_pkg::CMD_CLR) clr_idx_q <= clr_idx_q + IW'(1);
			if (cmd == ilff_pkg::CMD_G_HDR) brk_q <= brk_q + gsz_a;
			if (cfg_wr_en) chunk_q <= cfg_wr_data;
			if (cmd == ilff_pkg::CMD_EMIT) out_valid_q <= 1'b1;
			else if (!out_stall)           out_valid_q <= 1'b0;
		end
	end

	// status towards the controller
	always_comb begin
		st.clr_last  = (clr_idx_q == IW'(HEAP_WORDS - 1));
		st.in_free   = mode;
		st.in_zero   = (request_bytes == '0);
		st.chk_zero  = (rw[31:3] == '0);
		st.chk_fit   = !rw[0] && (ilff_pkg::addr_t'(need_q) <= rsz);
		st.pu        = pu_q;
		st.nu        = rw[0];
		st.oom       = (brk_q + gsz_a) > HEAP_BYTES;
		st.split     = split_q;
		st.mode_free = mode_q;
		st.out_full  = out_valid_q;
	end

	assign out_valid    = out_valid_q;
	assign payload_addr = out_addr_q;
	assign status       = out_st_q;

endmodule

### design/implicit_list_first_fit_allocator.sv
// Sequence: zero size goes straight to the result; free clears the used bit of the block
//   and merges it with free neighbours; allocate walks the heap first-fit, grows it when
//   no block fits and places the block, or reports out of memory when it cannot grow.
// Throughput: one request at a time; the next is taken the cycle after the result is
//   loaded, and a stalled result holds back only the result that follows it.
// Reset: a clearing pass over every heap word writes the post-init heap image first.
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator
// Boundary-tag heap allocator with first-fit walk, split, growth and merge.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator #(
	parameter int HEAP_WORDS = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ilff_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [ilff_pkg::REQ_W-1:0] request_bytes,
	input  logic [ilff_pkg::REQ_W-1:0] free_addr,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ilff_pkg::REQ_W-1:0] payload_addr,
	output logic [1:0]                 status
);

	ilff_pkg::cmd_t       cmd;
	ilff_pkg::dp_status_t st;

	// sequencer
	ilff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// heap store and arithmetic
	ilff_dpath #(
		.HEAP_WORDS (HEAP_WORDS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.mode          (mode),
		.request_bytes (request_bytes),
		.free_addr     (free_addr),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_addr  (payload_addr),
		.status        (status)
	);

endmodule

### tb/sv/implicit_list_first_fit_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator_test
// Drives allocate and free beats into the boundary-tag heap allocator, keeps
// its own word-level image of the heap to predict each result, and compares
// every result beat field by field across several chunk sizes.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator_test;

	localparam int          HEAP_WORDS = 65536;
	localparam int          CLK_HI     = 2;
	localparam int          CLK_LO     = 2;
	localparam int          RST_CYCLES = 11;
	localparam int          CYCLE_CAP  = 6000000;
	localparam int          IDLE_PCT   = 7;
	localparam int          PHASE_LEN  = 100;
	localparam logic        MODE_ALLOC = 1'b0;
	localparam logic        MODE_FREE  = 1'b1;

	typedef bit [63:0] u64_t;

	typedef struct {
		logic [ilff_pkg::REQ_W-1:0] addr;
		logic [1:0]                 st;
	} alloc_result_t;

	// heap image, pending results and live payloads
	class alloc_scoreboard;
		bit [31:0]                  heap[HEAP_WORDS];
		u64_t                       brk;
		u64_t                       chunk;
		alloc_result_t              pending[$];
		logic [ilff_pkg::REQ_W-1:0] live[$];
		int                         errors;

		function u64_t rd(u64_t a);
			u64_t i;
			i = a >> 2;
			if (i >= HEAP_WORDS) return 0;
			return u64_t'(heap[i]);
		endfunction

		function void wr(u64_t a, u64_t v);
			u64_t i;
			i = a >> 2;
			if (i < HEAP_WORDS) heap[i] = v[31:0];
		endfunction

		function u64_t tsize(u64_t a);
			return rd(a) & 64'hFFFF_FFF8;
		endfunction

		function u64_t tused(u64_t a);
			return rd(a) & 64'h1;
		endfunction

		function u64_t hd(u64_t p);
			return p - 4;
		endfunction

		function u64_t ft(u64_t p);
			return p + tsize(p - 4) - 8;
		endfunction

		function u64_t nxt(u64_t p);
			return p + tsize(p - 4);
		endfunction

		function u64_t prv(u64_t p);
			return p - tsize(p - 8);
		endfunction

		// footer location follows the freshly written header
		function void set_tags(u64_t p, u64_t s, u64_t u);
			wr(hd(p), (s & 64'hFFFF_FFFF) | u);
			wr(ft(p), (s & 64'hFFFF_FFFF) | u);
		endfunction

		// coalesce with free neighbours
		function u64_t coalesce(u64_t p);
			u64_t pu, nu, s, q, n, nf;
			pu = tused(ft(prv(p)));
			nu = tused(hd(nxt(p)));
			s  = tsize(hd(p));
			if (pu && nu) return p;
			if (pu) begin
				s += tsize(hd(nxt(p)));
				set_tags(p, s, 0);
				return p;
			end
			if (nu) begin
				q = prv(p);
				s += tsize(hd(q));
				wr(ft(p), s & 64'hFFFF_FFFF);
				wr(hd(q), s & 64'hFFFF_FFFF);
				return q;
			end
			q  = prv(p);
			n  = nxt(p);
			nf = ft(n);
			s += tsize(hd(q)) + tsize(nf);
			wr(hd(q), s & 64'hFFFF_FFFF);
			wr(nf, s & 64'hFFFF_FFFF);
			return q;
		endfunction

		// extend the break; zero when the store is full
		function bit raise_break(u64_t words, output u64_t res);
			u64_t s, p;
			s = words[0] ? (words + 1) * 4 : words * 4;
			p = brk;
			res = 0;
			if (p + s > HEAP_WORDS * 4) return 0;
			brk = p + s;
			wr(p - 4, s & 64'hFFFF_FFFF);
			wr(p + s - 8, s & 64'hFFFF_FFFF);
			wr(p + s - 4, 1);
			res = coalesce(p);
			return 1;
		endfunction

		function void place(u64_t p, u64_t want);
			u64_t have;
			have = tsize(hd(p));
			if (have >= want + 16) begin
				set_tags(p, want, 1);
				set_tags(nxt(p), have - want, 0);
			end else begin
				set_tags(p, have, 1);
			end
		endfunction

		function void init_heap();
			u64_t dummy;
			foreach (heap[i]) heap[i] = 0;
			chunk = 4096;
			wr(4, 9);
			wr(8, 9);
			wr(12, 1);
			brk = 16;
			void'(raise_break(1024, dummy));
			errors = 0;
		endfunction

		function void set_chunk(logic [ilff_pkg::CFG_W-1:0] v);
			chunk = u64_t'(v);
		endfunction

		// predict the result of one accepted request beat
		function void note(logic m, logic [ilff_pkg::REQ_W-1:0] req,
			logic [ilff_pkg::REQ_W-1:0] fa);
			alloc_result_t r;
			u64_t want, p, ext;
			bit found;
			r.addr = '0;
			r.st   = ilff_pkg::ST_OK;
			if (m == MODE_FREE) begin
				set_tags(u64_t'(fa), tsize(hd(u64_t'(fa))), 0);
				void'(coalesce(u64_t'(fa)));
				foreach (live[i]) if (live[i] == fa) begin
					live.delete(i);
					break;
				end
			end else if (req == 0) begin
				r.st = ilff_pkg::ST_ZERO;
			end else begin
				want  = (req <= 8) ? 16 : 8 * ((u64_t'(req) + 15) / 8);
				found = 0;
				for (p = 8; tsize(hd(p)) > 0; p = nxt(p)) begin
					if (!tused(hd(p)) && want <= tsize(hd(p))) begin
						found = 1;
						break;
					end
				end
				if (!found) begin
					ext = (want > chunk) ? want : chunk;
					if (!raise_break(ext / 4, p)) r.st = ilff_pkg::ST_OOM;
				end
				if (r.st == ilff_pkg::ST_OK) begin
					place(p, want);
					r.addr = p[ilff_pkg::REQ_W-1:0];
					live.push_back(r.addr);
				end
			end
			pending.push_back(r);
		endfunction

		function void check(logic [ilff_pkg::REQ_W-1:0] a, logic [1:0] s);
			alloc_result_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: payload_addr %0d status %0d", a, s);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a !== e.addr) begin
				$error("payload_addr: expected %0d, got %0d", e.addr, a);
				errors++;
			end
			if (s !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, s);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [ilff_pkg::CFG_W-1:0] cfg_wr_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       mode = MODE_ALLOC;
	logic [ilff_pkg::REQ_W-1:0] request_bytes = '0;
	logic [ilff_pkg::REQ_W-1:0] free_addr = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [ilff_pkg::REQ_W-1:0] payload_addr;
	logic [1:0]                 status;

	alloc_scoreboard  sb;
	bit               quiet = 0;
	int               cycles = 0;

	implicit_list_first_fit_allocator #(.HEAP_WORDS(HEAP_WORDS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.request_bytes (request_bytes),
		.free_addr     (free_addr),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_addr  (payload_addr),
		.status        (status)
	);

	always begin
		#CLK_HI clk = 1'b1;
		#CLK_LO clk = 1'b0;
	end

	// result side: random stall and checking of accepted beats
	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check(payload_addr, status);
		out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_req(logic m, logic [ilff_pkg::REQ_W-1:0] req,
		logic [ilff_pkg::REQ_W-1:0] fa);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		request_bytes <= req;
		free_addr     <= fa;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note(m, req, fa);
	endtask

	task automatic alloc_req(logic [ilff_pkg::REQ_W-1:0] req);
		send_req(MODE_ALLOC, req, ilff_pkg::REQ_W'($urandom_range(0, 262143)));
	endtask

	task automatic free_req(logic [ilff_pkg::REQ_W-1:0] fa);
		send_req(MODE_FREE, ilff_pkg::REQ_W'($urandom_range(0, 262143)), fa);
	endtask

	// hold the sender until every result has been handed over
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_chunk(logic [ilff_pkg::CFG_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_chunk(v);
	endtask

	// mostly small allocations and frees of live payloads
	task automatic random_phase(int n, bit pause_mid);
		int r;
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) drain();
			r = $urandom_range(0, 99);
			if (r < 40 && sb.live.size() > 0)
				free_req(sb.live[$urandom_range(0, sb.live.size() - 1)]);
			else if (r < 43) alloc_req('0);
			else if (r < 46) alloc_req(ilff_pkg::REQ_W'($urandom_range(0, 262143)));
			else if (r < 55) alloc_req(ilff_pkg::REQ_W'($urandom_range(1, 8192)));
			else alloc_req(ilff_pkg::REQ_W'($urandom_range(1, 256)));
		end
	endtask

	initial begin
		logic [ilff_pkg::REQ_W-1:0] blk[4];
		sb = new();
		sb.init_heap();
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sizes at the edges, zero size, out of memory, growth
		alloc_req(18'd0);
		alloc_req(18'd1);
		alloc_req(18'd8);
		alloc_req(18'd9);
		alloc_req(18'd262143);
		alloc_req(18'd4000);
		alloc_req(18'd5000);
		// four neighbouring blocks freed so that every merge case comes up
		for (int i = 0; i < 4; i++) begin
			alloc_req(18'd24);
			blk[i] = sb.live[$];
		end
		free_req(blk[1]);
		free_req(blk[2]);
		free_req(blk[0]);
		free_req(blk[3]);
		// payloads that were never handed out, at both ends of the range
		free_req(18'h00000);
		free_req(18'h3FFFF);
		alloc_req(18'd16);
		alloc_req(18'd17);

		random_phase(PHASE_LEN, 1);
		write_chunk(17'd8);
		quiet = 1;
		random_phase(PHASE_LEN, 0);
		quiet = 0;
		write_chunk(17'd65536);
		random_phase(PHASE_LEN, 0);
		write_chunk(17'($urandom_range(1, 8192) * 8));
		random_phase(PHASE_LEN, 0);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
